/* hw/rtl/lhs_pkg.sv */
// lhs_pkg: shared types, constants and codes of the latency histogram block
// used by lhs_ctrl, lhs_dpath and latency_histogram_by_size; no dependencies
package lhs_pkg;

  localparam int BUCKETS_DEF     = 24;
  localparam int KINDS_DEF       = 4;
  localparam int FIRST_SHIFT_DEF = 9;

  localparam int OP_W     = 2;
  localparam int KIND_W   = 2;
  localparam int SIZE_W   = 64;
  localparam int LAT_W    = 32;
  localparam int SEL_W    = 5;
  localparam int CNT_W    = 32;
  localparam int SUM_W    = 64;
  localparam int BLEN_W   = 6;

  localparam logic [OP_W-1:0] OP_RECORD = 2'd0;
  localparam logic [OP_W-1:0] OP_READ   = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

  localparam logic signed [LAT_W-1:0] EMPTY_LEAST = 32'sh7FFF_FFFF;
  localparam logic [SIZE_W-1:0]       SIZE_LIMIT  = 64'h0000_0000_FFFF_FFFF;

  typedef struct packed {
    logic signed [LAT_W-1:0] most;
    logic signed [LAT_W-1:0] least;
    logic [SUM_W-1:0]        total;
    logic [CNT_W-1:0]        count;
  } entry_t;

  localparam entry_t ENTRY_EMPTY = '{most: '0, least: EMPTY_LEAST, total: '0, count: '0};

  typedef struct packed {
    logic [SEL_W-1:0] idx;
    entry_t           ent;
  } result_t;

  typedef struct packed {
    logic capture;
    logic lookup;
    logic mem_read;
    logic commit;
  } cmd_t;

endpackage

/* hw/rtl/lhs_ctrl.sv */
// lhs_ctrl: sequencing state machine of the latency histogram block
// steps each item through capture, lookup, memory read and commit; uses lhs_pkg
module lhs_ctrl
  import lhs_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  output cmd_t cmd_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_LOOK = 2'd1;
  localparam logic [1:0] ST_READ = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       can_load;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign can_load    = !out_valid_q || out_ready_i;

  always_comb begin
    state_d         = state_q;
    out_valid_d     = out_valid_q && !out_ready_i;
    cmd_o.capture   = 1'b0;
    cmd_o.lookup    = 1'b0;
    cmd_o.mem_read  = 1'b0;
    cmd_o.commit    = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_LOOK;
        end
      end
      ST_LOOK: begin
        cmd_o.lookup = 1'b1;
        state_d      = ST_READ;
      end
      ST_READ: begin
        cmd_o.mem_read = 1'b1;
        state_d        = ST_DONE;
      end
      ST_DONE: begin
        if (can_load) begin
          cmd_o.commit = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  a_accept_to_lookup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == ST_LOOK))
    else $error("accepted item did not move to lookup");

  a_commit_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |-> (!out_valid_q || out_ready_i))
    else $error("result overwritten before it was taken");

  a_commit_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |=> (out_valid_q && state_q == ST_IDLE))
    else $error("commit did not present a result");

endmodule

/* hw/rtl/lhs_dpath.sv */
// lhs_dpath: bucket mapping, entry memory with valid bits, update and result register
// driven by commands from lhs_ctrl; uses lhs_pkg
module lhs_dpath
  import lhs_pkg::*;
#(
  parameter int BUCKETS     = BUCKETS_DEF,
  parameter int KINDS       = KINDS_DEF,
  parameter int FIRST_SHIFT = FIRST_SHIFT_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  cmd_t                    cmd_i,
  input  logic [OP_W-1:0]         opcode_i,
  input  logic [KIND_W-1:0]       kind_i,
  input  logic [SIZE_W-1:0]       request_size_i,
  input  logic signed [LAT_W-1:0] sample_latency_i,
  input  logic [SEL_W-1:0]        bucket_select_i,
  output result_t                 result_o
);

  localparam int DEPTH = KINDS * BUCKETS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int BKT_W = $clog2(BUCKETS);

  // input item
  logic [OP_W-1:0]         op_q;
  logic [KIND_W-1:0]       kind_q;
  logic [SIZE_W-1:0]       size_q;
  logic signed [LAT_W-1:0] lat_q;
  logic [SEL_W-1:0]        sel_q;

  // lookup
  logic [AW-1:0]    addr_q, addr_d;
  logic             hit_q, hit_d;
  logic [SEL_W-1:0] idx_q, idx_d;
  logic [31:0]      shifted;
  logic [BLEN_W-1:0] blen;
  logic [BKT_W-1:0] bkt;
  logic             kind_ok;
  logic             sel_ok;

  // memory
  entry_t           mem_q [DEPTH];
  logic [DEPTH-1:0] vld_q;
  entry_t           rd_q;
  logic             rd_vld_q;

  // update
  entry_t  ent;
  entry_t  upd;
  result_t res;
  result_t out_q;
  logic    wr_en;
  logic    clr_en;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q   <= opcode_i;
      kind_q <= kind_i;
      size_q <= request_size_i;
      lat_q  <= sample_latency_i;
      sel_q  <= bucket_select_i;
    end
  end

  assign shifted = size_q[31:0] >> FIRST_SHIFT;

  always_comb begin
    blen = '0;
    for (int i = 0; i < 32; i++) begin
      if (shifted[i]) begin
        blen = BLEN_W'(i + 1);
      end
    end
  end

  always_comb begin
    if (size_q > SIZE_LIMIT || {26'd0, blen} > 32'(BUCKETS - 1)) begin
      bkt = BKT_W'(BUCKETS - 1);
    end else begin
      bkt = BKT_W'(blen);
    end
  end

  assign kind_ok = {30'd0, kind_q} < 32'(KINDS);
  assign sel_ok  = {27'd0, sel_q} < 32'(BUCKETS);

  always_comb begin
    hit_d  = 1'b0;
    idx_d  = '0;
    addr_d = AW'(kind_q) * AW'(BUCKETS);
    case (op_q)
      OP_RECORD: begin
        hit_d  = kind_ok;
        idx_d  = SEL_W'(bkt);
        addr_d = AW'(kind_q) * AW'(BUCKETS) + AW'(bkt);
      end
      OP_READ: begin
        hit_d  = kind_ok && sel_ok;
        idx_d  = sel_q;
        addr_d = AW'(kind_q) * AW'(BUCKETS) + AW'(sel_q);
      end
      default: begin
        hit_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.lookup) begin
      addr_q <= addr_d;
      hit_q  <= hit_d;
      idx_q  <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_read) begin
      rd_q     <= mem_q[addr_q];
      rd_vld_q <= vld_q[addr_q];
    end
  end

  assign ent = rd_vld_q ? rd_q : ENTRY_EMPTY;

  always_comb begin
    upd.count = ent.count + CNT_W'(1);
    upd.total = ent.total + SUM_W'(lat_q);
    upd.least = (lat_q < ent.least) ? lat_q : ent.least;
    upd.most  = (lat_q > ent.most) ? lat_q : ent.most;
  end

  always_comb begin
    res.idx = idx_q;
    res.ent = ENTRY_EMPTY;
    if (hit_q) begin
      res.ent = (op_q == OP_RECORD) ? upd : ent;
    end
  end

  assign wr_en  = cmd_i.commit && hit_q && (op_q == OP_RECORD);
  assign clr_en = cmd_i.commit && (op_q == OP_CLEAR);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[addr_q] <= upd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (clr_en) begin
      vld_q <= '0;
    end else if (wr_en) begin
      vld_q[addr_q] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      out_q <= res;
    end
  end

  assign result_o = out_q;

  a_clear_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_en |=> (vld_q == '0))
    else $error("clear left entries marked valid");

  a_write_marks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |=> vld_q[$past(addr_q)])
    else $error("written entry not marked valid");

  a_miss_is_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.commit && !hit_q) |=> (out_q.ent == ENTRY_EMPTY))
    else $error("out of range item returned a non-empty entry");

endmodule

/* hw/rtl/latency_histogram_by_size.sv */
// latency_histogram_by_size: top level of the per-kind, per-size latency histogram
// instantiates lhs_ctrl and lhs_dpath; uses lhs_pkg
//
// Usage:
//   The slave stream takes one command item per handshake: tuser carries the
//   opcode (record, read, clear), tdata the kind, request size, latency and
//   bucket select. Every item gives exactly one result item on the master
//   stream: bucket index, sample count, latency sum, least and most latency.
//   A record updates one entry and returns it after the update, a read returns
//   one entry, a clear empties every entry at once through per-entry valid bits.
//   Items are worked one at a time: capture, lookup, memory read, commit.
//   The result register is loaded at commit, and the block returns to idle with
//   it, so the next item is taken after the commit; the entry memory is read
//   in its own step and written back at commit.
//   The result sits in an output register; a new item is taken while it waits,
//   and the commit of that item holds until the receiver takes the old result.
//   Reset empties all entries and leaves the block idle with no result pending.
module latency_histogram_by_size
  import lhs_pkg::*;
#(
  parameter int BUCKETS     = BUCKETS_DEF,
  parameter int KINDS       = KINDS_DEF,
  parameter int FIRST_SHIFT = FIRST_SHIFT_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // kind[1:0], request_size[65:2], sample_latency[97:66], bucket_select[102:98], zero pad
  input  logic [103:0] s_axis_tdata,
  // opcode[1:0]
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // bucket_index[4:0], sample_count[36:5], latency_total[100:37],
  // latency_least[132:101], latency_most[164:133], zero pad
  output logic [167:0] m_axis_tdata
);

  cmd_t    cmd;
  result_t result;

  lhs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (cmd)
  );

  lhs_dpath #(
    .BUCKETS     (BUCKETS),
    .KINDS       (KINDS),
    .FIRST_SHIFT (FIRST_SHIFT)
  ) u_dpath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .opcode_i         (s_axis_tuser),
    .kind_i           (s_axis_tdata[1:0]),
    .request_size_i   (s_axis_tdata[65:2]),
    .sample_latency_i (s_axis_tdata[97:66]),
    .bucket_select_i  (s_axis_tdata[102:98]),
    .result_o         (result)
  );

  assign m_axis_tdata = {3'd0, result.ent.most, result.ent.least, result.ent.total,
                         result.ent.count, result.idx};

endmodule
